### design/date_offset_by_days_unit_macros.svh
// Assertion macros for the date offset unit.
// Uses clk and rst from the including module's scope.
`ifndef DATE_OFFSET_BY_DAYS_UNIT_MACROS_SVH
`define DATE_OFFSET_BY_DAYS_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DOBD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("dobd: assertion failed");
`define DOBD_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("dobd: assertion failed during or after reset");
`else
`define DOBD_ASSERT(lbl, prop)
`define DOBD_ASSERT_RST(lbl, prop)
`endif
`endif

### design/dobd_pkg.sv
// Shared types, constants and the month length function of the date offset unit.
// No dependencies.
package dobd_pkg;

  localparam int MAX_OFFSET = 32767;
  localparam int CNT_W      = $clog2(MAX_OFFSET + 1);

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int CFG_YEAR_W = 14;
  localparam int YEAR_W  = 16;
  localparam int RES_YEAR_W = 15;
  localparam int OFS_W   = 16;
  localparam int CFG_W   = 14;
  localparam int IDX_W   = 2;
  localparam int REM_W   = CFG_YEAR_W;

  localparam int LEAP_CYCLE = 400;
  localparam int CENTURY    = 100;

  localparam logic [IDX_W-1:0] REG_BASE_DAY   = 2'd0;
  localparam logic [IDX_W-1:0] REG_BASE_MONTH = 2'd1;
  localparam logic [IDX_W-1:0] REG_BASE_YEAR  = 2'd2;

  localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

  localparam logic [DAY_W-1:0] DAYS_31   = 5'd31;
  localparam logic [DAY_W-1:0] DAYS_30   = 5'd30;
  localparam logic [DAY_W-1:0] DAYS_29   = 5'd29;
  localparam logic [DAY_W-1:0] DAYS_28   = 5'd28;
  localparam logic [DAY_W-1:0] FIRST_DAY = 5'd1;

  typedef struct packed {
    logic [DAY_W-1:0]      day;
    logic [MONTH_W-1:0]    month;
    logic [CFG_YEAR_W-1:0] year;
  } base_cfg_t;

  typedef struct packed {
    logic [DAY_W-1:0]        day;
    logic [MONTH_W-1:0]      month;
    logic signed [YEAR_W-1:0] year;
  } date_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    case (month) inside
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = DAYS_30;
      MON_FEB: len = leap ? DAYS_29 : DAYS_28;
      default: len = DAYS_31;
    endcase
    return len;
  endfunction

endpackage

### design/dobd_step_unit.sv
// One-day step unit: next or previous calendar day, with year mod 400 tracking.
// Depends on dobd_pkg.
module dobd_step_unit (
  input  dobd_pkg::date_t               cur,
  input  logic [dobd_pkg::REM_W-1:0]    rem,
  input  logic                          backward,
  output logic [dobd_pkg::DAY_W-1:0]    len,
  output dobd_pkg::date_t               nxt,
  output logic [dobd_pkg::REM_W-1:0]    nxt_rem
);
  import dobd_pkg::*;

  logic                 leap;
  logic [MONTH_W-1:0]   prev_month;
  logic [DAY_W-1:0]     prev_len;
  logic [REM_W-1:0]     rem_inc;
  logic [REM_W-1:0]     rem_dec;

  assign leap = (rem == '0) ||
                (cur.year[1:0] == 2'b00 && rem != REM_W'(CENTURY) &&
                 rem != REM_W'(2 * CENTURY) && rem != REM_W'(3 * CENTURY));
  assign len        = month_len(cur.month, leap);
  assign prev_month = (cur.month == MON_JAN) ? MON_DEC : cur.month - 1'b1;
  assign prev_len   = month_len(prev_month, leap);
  assign rem_inc    = (rem == REM_W'(LEAP_CYCLE - 1)) ? '0 : rem + 1'b1;
  assign rem_dec    = (rem == '0) ? REM_W'(LEAP_CYCLE - 1) : rem - 1'b1;

  always_comb begin
    nxt     = cur;
    nxt_rem = rem;
    if (!backward) begin
      if (cur.day >= len) begin
        nxt.day = FIRST_DAY;
        if (cur.month < MON_DEC) begin
          nxt.month = cur.month + 1'b1;
        end else begin
          nxt.month = MON_JAN;
          nxt.year  = cur.year + YEAR_W'(1);
          nxt_rem   = rem_inc;
        end
      end else begin
        nxt.day = cur.day + 1'b1;
      end
    end else begin
      if (cur.day <= FIRST_DAY) begin
        if (cur.month > MON_JAN) begin
          nxt.month = prev_month;
          nxt.day   = prev_len;
        end else begin
          nxt.month = MON_DEC;
          nxt.day   = DAYS_31;
          nxt.year  = cur.year - YEAR_W'(1);
          nxt_rem   = rem_dec;
        end
      end else begin
        nxt.day = cur.day - 1'b1;
      end
    end
  end

endmodule

### design/dobd_ctrl.sv
// Sequencer: latches a transaction, reduces year mod 400, clamps the day,
// then drives the shared step unit once per day. Depends on dobd_pkg, dobd_step_unit.
module dobd_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  dobd_pkg::base_cfg_t               base,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [dobd_pkg::OFS_W-1:0] day_offset,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dobd_pkg::DAY_W-1:0]        result_day,
  output logic [dobd_pkg::MONTH_W-1:0]      result_month,
  output logic signed [dobd_pkg::RES_YEAR_W-1:0] result_year
);
  import dobd_pkg::*;

  `include "date_offset_by_days_unit_macros.svh"

  typedef enum logic [1:0] {ST_IDLE, ST_MOD, ST_CLAMP, ST_STEP} state_t;

  state_t             state;
  date_t              cur;
  logic [REM_W-1:0]   rem;
  logic               backward;
  logic [CNT_W-1:0]   cnt;

  logic [DAY_W-1:0]   len;
  date_t              nxt;
  logic [REM_W-1:0]   nxt_rem;
  logic signed [OFS_W:0] off_ext;
  logic [OFS_W:0]     off_mag;
  logic [CNT_W-1:0]   cnt_start;
  logic               load_out;
  logic               date_ok;

  dobd_step_unit u_step (
    .cur      (cur),
    .rem      (rem),
    .backward (backward),
    .len      (len),
    .nxt      (nxt),
    .nxt_rem  (nxt_rem)
  );

  assign in_ready  = (state == ST_IDLE);
  assign off_ext   = {day_offset[OFS_W-1], day_offset};
  assign off_mag   = day_offset[OFS_W-1] ? (OFS_W+1)'(-off_ext) : (OFS_W+1)'(off_ext);
  assign cnt_start = (32'(off_mag) > 32'(MAX_OFFSET)) ? CNT_W'(MAX_OFFSET)
                                                      : CNT_W'(off_mag);
  assign load_out  = (state == ST_STEP) && (cnt == '0) && (!out_valid || out_ready);
  assign date_ok   = (cur.day != '0) && (cur.day <= len) &&
                     (cur.month != '0) && (cur.month <= MON_DEC);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cur.day   <= (base.day == '0) ? FIRST_DAY : base.day;
            cur.month <= (base.month == '0) ? MON_JAN :
                         (base.month > MON_DEC) ? MON_DEC : base.month;
            cur.year  <= signed'({{(YEAR_W-CFG_YEAR_W){1'b0}}, base.year});
            rem       <= base.year;
            backward  <= day_offset[OFS_W-1];
            cnt       <= cnt_start;
            state     <= ST_MOD;
          end
        end
        ST_MOD: begin
          if (rem >= REM_W'(LEAP_CYCLE)) begin
            rem <= rem - REM_W'(LEAP_CYCLE);
          end else begin
            state <= ST_CLAMP;
          end
        end
        ST_CLAMP: begin
          if (cur.day > len) begin
            cur.day <= len;
          end
          state <= ST_STEP;
        end
        ST_STEP: begin
          if (cnt != '0) begin
            cur <= nxt;
            rem <= nxt_rem;
            cnt <= cnt - 1'b1;
          end else if (load_out) begin
            result_day   <= cur.day;
            result_month <= cur.month;
            result_year  <= cur.year[RES_YEAR_W-1:0];
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `DOBD_ASSERT(a_date_sane, (state == ST_STEP) |-> date_ok)
  `DOBD_ASSERT(a_rem_reduced, (state == ST_STEP) |-> (rem < REM_W'(LEAP_CYCLE)))
  `DOBD_ASSERT(a_cnt_down, (state == ST_STEP && cnt != '0) |=> (cnt == $past(cnt) - 1'b1))
  `DOBD_ASSERT_RST(a_result_from_step, (!rst && $rose(out_valid)) |-> $past(state == ST_STEP))

endmodule

### design/date_offset_by_days_unit.sv
// Date offset unit top level: configuration registers and the day-step sequencer.
// Depends on dobd_pkg, dobd_ctrl.
//
// Moves a Gregorian base date (registers 0 day, 1 month, 2 year) by the signed
// day count of each input transaction and returns the moved date.
// Configuration: cfg_we writes cfg_data into register cfg_index at the clock
// edge; index 3 is ignored. Write only while no transaction is in flight.
// Input: in_valid/in_ready with day_offset; accepted when both are high.
// in_ready is high only while the sequencer is idle.
// Output: out_valid/out_ready with result_day, result_month, result_year,
// held in an output register until taken.
// Sequence: latch the transaction, reduce the year mod 400 (one subtract of
// 400 per cycle), clamp the day, step one day of offset per cycle (up to
// 32767) through the shared step unit, and load the output register. One
// transaction is in flight at a time.
// If the receiver stalls, the next result waits in the sequencer until the
// output register frees; in_ready stays low meanwhile.
// Reset: base date 1 January 2000, sequencer idle, no result pending.
module date_offset_by_days_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [dobd_pkg::IDX_W-1:0]        cfg_index,
  input  logic [dobd_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [dobd_pkg::OFS_W-1:0] day_offset,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dobd_pkg::DAY_W-1:0]        result_day,
  output logic [dobd_pkg::MONTH_W-1:0]      result_month,
  output logic signed [dobd_pkg::RES_YEAR_W-1:0] result_year
);
  import dobd_pkg::*;

  base_cfg_t base;

  always_ff @(posedge clk) begin
    if (rst) begin
      base.day   <= FIRST_DAY;
      base.month <= MON_JAN;
      base.year  <= CFG_YEAR_W'(2000);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE_DAY:   base.day   <= cfg_data[DAY_W-1:0];
        REG_BASE_MONTH: base.month <= cfg_data[MONTH_W-1:0];
        REG_BASE_YEAR:  base.year  <= cfg_data[CFG_YEAR_W-1:0];
        default: ;
      endcase
    end
  end

  dobd_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .base         (base),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .day_offset   (day_offset),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_day   (result_day),
    .result_month (result_month),
    .result_year  (result_year)
  );

endmodule
